[rtl/assert_macros.svh]
// Assertion macros for the RTL of the I2C register access master.
// No dependencies; included by each file that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/i2cmra_pkg.sv]
// Package for the I2C register access master: beat structs, request and
// configuration codes, and the sequencer state encodings. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cmra_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_BEGIN  = 2'd1;
    localparam logic [1:0] REQ_SUPPLY = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ACK_TIMEOUT = 1'b0;
    localparam logic CFG_WRITE_GAP   = 1'b1;

    localparam int unsigned CfgDataWidth = 8;

    // Reset values of the configuration registers.
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [3:0] WRITE_GAP_RESET   = 4'd2;

    // Input beat.
    typedef struct packed {
        logic [1:0] req_type;
        logic       sda_sample;
        logic       is_read;
        logic [7:0] dev_address;
        logic [7:0] reg_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
    } t_in_item;

    // Result beat.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       need_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       busy_res;
        logic       done_res;
        logic       error;
    } t_out_item;

    // Bus sequencer phases, one-hot.
    typedef enum logic [17:0] {
        PH_IDLE     = 18'h00001,
        PH_ST_A     = 18'h00002,
        PH_ST_B     = 18'h00004,
        PH_TX_LO    = 18'h00008,
        PH_TX_HI    = 18'h00010,
        PH_TX_END   = 18'h00020,
        PH_ACK_SET  = 18'h00040,
        PH_ACK_POLL = 18'h00080,
        PH_NEED     = 18'h00100,
        PH_STOP_A   = 18'h00200,
        PH_STOP_B   = 18'h00400,
        PH_RX_LO    = 18'h00800,
        PH_RX_HI    = 18'h01000,
        PH_RXA_LO   = 18'h02000,
        PH_RXA_HI   = 18'h04000,
        PH_FIN_A    = 18'h08000,
        PH_FIN_B    = 18'h10000,
        PH_GAP      = 18'h20000
    } t_phase;

    // Which byte of the transaction is on the bus, one-hot.
    typedef enum logic [3:0] {
        STG_DEV   = 4'b0001,
        STG_REG   = 4'b0010,
        STG_RADDR = 4'b0100,
        STG_DATA  = 4'b1000
    } t_stage;

endpackage

`default_nettype wire

[rtl/i2c_master_register_access.sv]
// I2C master for register-addressed reads and writes, one bus phase per tick beat.
// The result beat of an accepted item is registered and shown in the next cycle.
// One item per cycle when not stalled: the single output register refills as it drains.
// Input stall rises only while a result waits and the output side is stalled.
// Reset (synchronous, active low): sequencer idle, error clear, ACK timeout 250, gap 2.
// Depends on i2cmra_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module i2c_master_register_access
    import i2cmra_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire t_in_item                i_in_data,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output t_out_item                    o_out_data,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_index,
    input  wire logic [CfgDataWidth-1:0] i_cfg_data
);

    // Sequencer state.
    t_phase     r_phase, n_phase;
    t_stage     r_stage, n_stage;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_wait, n_wait;
    logic [7:0] r_saved_dev, n_saved_dev;
    logic [7:0] r_saved_reg, n_saved_reg;
    logic       r_read_mode, n_read_mode;
    logic       r_error_flag, n_error_flag;

    // Configuration.
    logic [7:0] r_ack_timeout;
    logic [3:0] r_write_gap;

    // Output register.
    logic       r_out_valid;
    t_out_item  r_out_data, n_out_data;

    logic       w_accept;
    logic       w_is_tick;
    logic       w_after_ack;

    // Line levels for a phase, given the current data bit and the NACK condition.
    function automatic logic [2:0] phase_levels(input t_phase ph, input logic bit_out,
                                                input logic nack);
        logic [2:0] lv;   // {scl, sda, drive}
        begin
            lv = 3'b000;
            unique case (ph)
                PH_IDLE, PH_ST_A, PH_GAP:         lv = 3'b111;
                PH_ST_B, PH_STOP_B, PH_FIN_B:     lv = 3'b101;
                PH_TX_LO, PH_TX_END:              lv = {1'b0, bit_out, 1'b1};
                PH_TX_HI:                         lv = {1'b1, bit_out, 1'b1};
                PH_ACK_SET, PH_ACK_POLL, PH_RX_HI: lv = 3'b100;
                PH_STOP_A, PH_FIN_A:              lv = 3'b001;
                PH_RXA_LO:                        lv = {1'b0, nack, 1'b1};
                PH_RXA_HI:                        lv = {1'b1, nack, 1'b1};
                default:                          lv = 3'b000;
            endcase
            return lv;
        end
    endfunction

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_is_tick   = (i_in_data.req_type == REQ_TICK);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Next state and result for the beat at the input.
    always_comb begin
        logic [2:0] lv;
        logic [7:0] rx_shift;
        logic       rvalid;
        logic       done;

        n_phase      = r_phase;
        n_stage      = r_stage;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_wait       = r_wait;
        n_saved_dev  = r_saved_dev;
        n_saved_reg  = r_saved_reg;
        n_read_mode  = r_read_mode;
        n_error_flag = r_error_flag;
        w_after_ack  = 1'b0;
        rvalid       = 1'b0;
        done         = 1'b0;
        rx_shift     = {r_shift[6:0], i_in_data.sda_sample};

        if (w_is_tick) begin
            // One bus phase.
            unique case (r_phase)
                PH_ST_A: n_phase = PH_ST_B;
                PH_ST_B: begin
                    n_shift = (r_stage == STG_RADDR) ? r_saved_dev + 8'd1 : r_saved_dev;
                    n_bit   = 3'd7;
                    n_phase = PH_TX_LO;
                end
                PH_TX_LO: n_phase = PH_TX_HI;
                PH_TX_HI: n_phase = PH_TX_END;
                PH_TX_END: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    if (r_bit == 3'd0) begin
                        n_wait  = 8'd0;
                        n_phase = PH_ACK_SET;
                    end else begin
                        n_bit   = r_bit - 3'd1;
                        n_phase = PH_TX_LO;
                    end
                end
                PH_ACK_SET: n_phase = PH_ACK_POLL;
                PH_ACK_POLL: begin
                    if (!i_in_data.sda_sample) begin
                        w_after_ack = 1'b1;
                    end else if (r_wait >= r_ack_timeout) begin
                        n_error_flag = 1'b1;
                        n_phase      = PH_STOP_A;
                    end else begin
                        n_wait = r_wait + 8'd1;
                    end
                end
                PH_STOP_A: n_phase = PH_STOP_B;
                PH_STOP_B: w_after_ack = 1'b1;
                PH_RX_LO: n_phase = PH_RX_HI;
                PH_RX_HI: begin
                    n_shift = rx_shift;
                    if (r_bit == 3'd0) begin
                        rvalid  = 1'b1;
                        n_phase = PH_RXA_LO;
                    end else begin
                        n_bit   = r_bit - 3'd1;
                        n_phase = PH_RX_LO;
                    end
                end
                PH_RXA_LO: n_phase = PH_RXA_HI;
                PH_RXA_HI: begin
                    // Bytes left counts down to the byte just acknowledged.
                    if (r_bytes_left > 8'd1) begin
                        n_bytes_left = r_bytes_left - 8'd1;
                        n_bit        = 3'd7;
                        n_shift      = 8'd0;
                        n_phase      = PH_RX_LO;
                    end else begin
                        n_bytes_left = 8'd0;
                        n_phase      = PH_FIN_A;
                    end
                end
                PH_FIN_A: n_phase = PH_FIN_B;
                PH_FIN_B: begin
                    if (!r_read_mode && (r_write_gap != 4'd0)) begin
                        n_wait  = {4'd0, r_write_gap};
                        n_phase = PH_GAP;
                    end else begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                end
                PH_GAP: begin
                    if (r_wait <= 8'd1) begin
                        n_wait  = 8'd0;
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_wait = r_wait - 8'd1;
                    end
                end
                default: ;
            endcase
        end else if ((i_in_data.req_type == REQ_BEGIN) && (r_phase == PH_IDLE)) begin
            // Start of a transaction.
            n_read_mode  = i_in_data.is_read;
            n_saved_dev  = i_in_data.dev_address;
            n_saved_reg  = i_in_data.reg_address;
            n_bytes_left = i_in_data.byte_count;
            n_error_flag = 1'b0;
            n_wait       = 8'd0;
            n_bit        = 3'd0;
            n_shift      = 8'd0;
            n_stage      = STG_DEV;
            n_phase      = PH_ST_A;
        end else if ((i_in_data.req_type == REQ_SUPPLY) && (r_phase == PH_NEED)) begin
            // Requested write data byte arrives.
            if (r_bytes_left != 8'd0) begin
                n_bytes_left = r_bytes_left - 8'd1;
            end
            n_shift = i_in_data.write_byte;
            n_bit   = 3'd7;
            n_phase = PH_TX_LO;
        end

        // Continue after an ACK, seen or timed out.
        if (w_after_ack) begin
            unique case (r_stage)
                STG_DEV: begin
                    n_stage = STG_REG;
                    n_shift = r_saved_reg;
                    n_bit   = 3'd7;
                    n_phase = PH_TX_LO;
                end
                STG_REG: begin
                    if (r_read_mode) begin
                        n_stage = STG_RADDR;
                        n_phase = PH_ST_A;
                    end else if (r_bytes_left != 8'd0) begin
                        n_stage = STG_DATA;
                        n_phase = PH_NEED;
                    end else begin
                        n_phase = PH_FIN_A;
                    end
                end
                STG_RADDR: begin
                    if (r_bytes_left != 8'd0) begin
                        n_bit   = 3'd7;
                        n_shift = 8'd0;
                        n_phase = PH_RX_LO;
                    end else begin
                        n_phase = PH_FIN_A;
                    end
                end
                default: begin
                    n_phase = (r_bytes_left != 8'd0) ? PH_NEED : PH_FIN_A;
                end
            endcase
        end

        // A tick shows the phase it ran; other beats show the pending phase.
        if (w_is_tick) begin
            lv = phase_levels(r_phase, r_shift[7], (r_bytes_left <= 8'd1));
        end else begin
            lv = phase_levels(n_phase, n_shift[7], (n_bytes_left <= 8'd1));
        end

        n_out_data.scl_level  = lv[2];
        n_out_data.sda_level  = lv[1];
        n_out_data.sda_drive  = lv[0];
        n_out_data.need_byte  = (n_phase == PH_NEED);
        n_out_data.read_valid = rvalid;
        n_out_data.read_byte  = rvalid ? rx_shift : 8'd0;
        n_out_data.read_last  = rvalid && (r_bytes_left <= 8'd1);
        n_out_data.busy_res   = (n_phase != PH_IDLE);
        n_out_data.done_res   = done;
        n_out_data.error      = n_error_flag;
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_stage      <= STG_DEV;
            r_bit        <= 3'd0;
            r_shift      <= 8'd0;
            r_bytes_left <= 8'd0;
            r_wait       <= 8'd0;
            r_saved_dev  <= 8'd0;
            r_saved_reg  <= 8'd0;
            r_read_mode  <= 1'b0;
            r_error_flag <= 1'b0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_stage      <= n_stage;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_wait       <= n_wait;
            r_saved_dev  <= n_saved_dev;
            r_saved_reg  <= n_saved_reg;
            r_read_mode  <= n_read_mode;
            r_error_flag <= n_error_flag;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RESET;
            r_write_gap   <= WRITE_GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data[7:0];
                CFG_WRITE_GAP:   r_write_gap   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Output register: loads on every accepted beat, empties when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    // The error flag is cleared only by a new transaction.
    `ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n,
        r_error_flag && !(w_accept && (i_in_data.req_type == REQ_BEGIN)), r_error_flag,
        "error flag dropped without a new transaction")
    // A finished transaction is never reported as busy.
    `ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n,
        r_out_valid && r_out_data.done_res, !r_out_data.busy_res,
        "done reported while busy")
    // Data requests only happen inside a write.
    `ASSERT_SAME(a_need_in_write, i_clk, i_rst_n,
        r_out_valid && r_out_data.need_byte, r_out_data.busy_res && !r_read_mode,
        "byte requested outside a write")
    // Received bytes only come out of a read.
    `ASSERT_SAME(a_rx_in_read, i_clk, i_rst_n,
        r_out_valid && r_out_data.read_valid, r_read_mode && (r_phase == PH_RXA_LO),
        "read byte outside a read")

endmodule

`default_nettype wire

[test/i2c_master_register_access_tb.sv]
// Self-checking testbench for the I2C register access master: a directed table, then
// random transaction traffic checked beat by beat against an in-bench phase predictor.
// Depends on i2cmra_pkg and the i2c_master_register_access RTL.
`timescale 1ns / 1ps

module i2c_master_register_access_tb;
    import i2cmra_pkg::*;

    // Request code that the block ignores; the package names only the other three.
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 500000;

    // Result beats that can be read straight off the line levels.
    // Idle: SCL and SDA both driven high, nothing else set.
    localparam t_out_item OUT_IDLE     = {3'b111, 14'd0};
    // Idle after a transaction whose ACK went missing: the sticky error stays up.
    localparam t_out_item OUT_IDLE_ERR = {3'b111, 13'd0, 1'b1};
    // A begin beat accepted while idle: start condition pending, busy set, error cleared.
    localparam t_out_item OUT_START    = {3'b111, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0};

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    t_in_item                i_in_data   = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    t_out_item               o_out_data;
    logic                    i_cfg_we    = 1'b0;
    logic                    i_cfg_index = 1'b0;
    logic [CfgDataWidth-1:0] i_cfg_data  = '0;

    i2c_master_register_access u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Shadow of the bus sequencer and its configuration.
    t_phase      seq_phase = PH_IDLE;
    t_stage      stage_q   = STG_DEV;
    logic [2:0]  bit_cnt   = '0;
    logic [7:0]  shift_q   = '0;
    logic [7:0]  left_q    = '0;
    logic [7:0]  wait_q    = '0;
    logic [7:0]  dev_q     = '0;
    logic [7:0]  regad_q   = '0;
    logic        rd_mode   = 1'b0;
    logic        err_q     = 1'b0;
    logic [7:0]  ack_limit = ACK_TIMEOUT_RESET;
    logic [3:0]  gap_len   = WRITE_GAP_RESET;

    t_out_item   line_results_q[$];
    int unsigned fail_cnt  = 0;
    int unsigned cycle_cnt = 0;
    int          hold_left = 0;
    bit          quiet     = 1'b0;

    // One row of the directed table. A row with reps of zero repeats its tick beat
    // until the predicted phase reaches stop_at.
    typedef struct {
        t_in_item  item;
        int        reps;
        t_phase    stop_at;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    t_dir_row dir_rows[$];

    // Levels {scl, sda, drive} that a phase puts on the bus.
    function automatic logic [2:0] line_levels(t_phase p);
        logic bit_out;
        logic nack;
        bit_out = shift_q[7];
        nack    = (left_q <= 8'd1);
        case (p)
            PH_IDLE, PH_ST_A, PH_GAP:      return 3'b111;
            PH_ST_B, PH_STOP_B, PH_FIN_B:  return 3'b101;
            PH_TX_LO, PH_TX_END:           return {1'b0, bit_out, 1'b1};
            PH_TX_HI:                      return {1'b1, bit_out, 1'b1};
            PH_ACK_SET, PH_ACK_POLL,
            PH_RX_HI:                      return 3'b100;
            PH_STOP_A, PH_FIN_A:           return 3'b001;
            PH_RXA_LO:                     return {1'b0, nack, 1'b1};
            PH_RXA_HI:                     return {1'b1, nack, 1'b1};
            default:                       return 3'b000;
        endcase
    endfunction

    function automatic void load_byte(logic [7:0] b);
        shift_q   = b;
        bit_cnt   = 3'd7;
        seq_phase = PH_TX_LO;
    endfunction

    // Move on once a byte has been acknowledged, or its missing ACK has been closed off.
    function automatic void byte_acked();
        case (stage_q)
            STG_DEV: begin
                stage_q = STG_REG;
                load_byte(regad_q);
            end
            STG_REG: begin
                if (rd_mode) begin
                    stage_q   = STG_RADDR;
                    seq_phase = PH_ST_A;
                end else if (left_q != 0) begin
                    stage_q   = STG_DATA;
                    seq_phase = PH_NEED;
                end else begin
                    seq_phase = PH_FIN_A;
                end
            end
            STG_RADDR: begin
                if (left_q != 0) begin
                    bit_cnt   = 3'd7;
                    shift_q   = '0;
                    seq_phase = PH_RX_LO;
                end else begin
                    seq_phase = PH_FIN_A;
                end
            end
            default: seq_phase = (left_q != 0) ? PH_NEED : PH_FIN_A;
        endcase
    endfunction

    // Advance the shadow sequencer by one input beat and return the result beat.
    function automatic t_out_item i2c_phase_step(t_in_item it);
        t_out_item r;
        t_phase    p;
        logic [2:0] lv;
        r = '0;
        if (it.req_type == REQ_TICK) begin
            p  = seq_phase;
            lv = line_levels(p);
            case (p)
                PH_ST_A:   seq_phase = PH_ST_B;
                PH_ST_B:   load_byte(stage_q == STG_RADDR ? dev_q + 8'd1 : dev_q);
                PH_TX_LO:  seq_phase = PH_TX_HI;
                PH_TX_HI:  seq_phase = PH_TX_END;
                PH_TX_END: begin
                    shift_q = shift_q << 1;
                    if (bit_cnt == 0) begin
                        wait_q    = '0;
                        seq_phase = PH_ACK_SET;
                    end else begin
                        bit_cnt   = bit_cnt - 3'd1;
                        seq_phase = PH_TX_LO;
                    end
                end
                PH_ACK_SET: seq_phase = PH_ACK_POLL;
                PH_ACK_POLL: begin
                    if (!it.sda_sample) begin
                        byte_acked();
                    end else if (wait_q >= ack_limit) begin
                        err_q     = 1'b1;
                        seq_phase = PH_STOP_A;
                    end else begin
                        wait_q = wait_q + 8'd1;
                    end
                end
                PH_STOP_A: seq_phase = PH_STOP_B;
                PH_STOP_B: byte_acked();
                PH_RX_LO:  seq_phase = PH_RX_HI;
                PH_RX_HI: begin
                    shift_q = {shift_q[6:0], it.sda_sample};
                    if (bit_cnt == 0) begin
                        r.read_valid = 1'b1;
                        r.read_byte  = shift_q;
                        r.read_last  = (left_q <= 8'd1);
                        seq_phase    = PH_RXA_LO;
                    end else begin
                        bit_cnt   = bit_cnt - 3'd1;
                        seq_phase = PH_RX_LO;
                    end
                end
                PH_RXA_LO: seq_phase = PH_RXA_HI;
                PH_RXA_HI: begin
                    if (left_q != 0) left_q = left_q - 8'd1;
                    if (left_q != 0) begin
                        bit_cnt   = 3'd7;
                        shift_q   = '0;
                        seq_phase = PH_RX_LO;
                    end else begin
                        seq_phase = PH_FIN_A;
                    end
                end
                PH_FIN_A: seq_phase = PH_FIN_B;
                PH_FIN_B: begin
                    if (!rd_mode && gap_len != 0) begin
                        wait_q    = {4'd0, gap_len};
                        seq_phase = PH_GAP;
                    end else begin
                        seq_phase  = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
                PH_GAP: begin
                    if (wait_q != 0) wait_q = wait_q - 8'd1;
                    if (wait_q == 0) begin
                        seq_phase  = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
                default: ;
            endcase
        end else begin
            if (it.req_type == REQ_BEGIN && seq_phase == PH_IDLE) begin
                rd_mode   = it.is_read;
                dev_q     = it.dev_address;
                regad_q   = it.reg_address;
                left_q    = it.byte_count;
                err_q     = 1'b0;
                wait_q    = '0;
                bit_cnt   = '0;
                shift_q   = '0;
                stage_q   = STG_DEV;
                seq_phase = PH_ST_A;
            end else if (it.req_type == REQ_SUPPLY && seq_phase == PH_NEED) begin
                if (left_q != 0) left_q = left_q - 8'd1;
                load_byte(it.write_byte);
            end
            lv = line_levels(seq_phase);
        end
        r.scl_level = lv[2];
        r.sda_level = lv[1];
        r.sda_drive = lv[0];
        r.need_byte = (seq_phase == PH_NEED);
        r.busy_res  = (seq_phase != PH_IDLE);
        r.error     = err_q;
        return r;
    endfunction

    function automatic t_in_item mk_item(logic [1:0] req, logic sda, logic rd,
                                         logic [7:0] dev, logic [7:0] rg,
                                         logic [7:0] cnt, logic [7:0] wbyte);
        t_in_item it;
        it.req_type    = req;
        it.sda_sample  = sda;
        it.is_read     = rd;
        it.dev_address = dev;
        it.reg_address = rg;
        it.byte_count  = cnt;
        it.write_byte  = wbyte;
        return it;
    endfunction

    function automatic void add_row(t_in_item it, int reps, t_phase stop_at,
                                    bit typed, t_out_item want);
        t_dir_row row;
        row.item    = it;
        row.reps    = reps;
        row.stop_at = stop_at;
        row.typed   = typed;
        row.want    = want;
        dir_rows.push_back(row);
    endfunction

    // Random beat shaped by the predicted phase: mostly the beat a well-behaved host
    // would send next, with random content, and a share of stray requests.
    function automatic t_in_item next_item();
        t_in_item    it;
        logic [63:0] raw;
        int unsigned pick;
        raw  = {$urandom(), $urandom()};
        it   = raw[$bits(t_in_item)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 8) return it;
        case (seq_phase)
            PH_IDLE: begin
                it.req_type = REQ_BEGIN;
                pick = $urandom_range(0, 99);
                if (pick < 60)      it.byte_count = 8'($urandom_range(0, 2));
                else if (pick < 93) it.byte_count = 8'($urandom_range(3, 6));
                else                it.byte_count = 8'($urandom_range(7, 16));
            end
            PH_NEED:     it.req_type = REQ_SUPPLY;
            PH_ACK_POLL: begin
                it.req_type   = REQ_TICK;
                it.sda_sample = ($urandom_range(0, 99) < 35);
            end
            default:     it.req_type = REQ_TICK;
        endcase
        return it;
    endfunction

    // Offer one input beat, predict its result once it is taken.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item pred;
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 27) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = i2c_phase_step(it);
        line_results_q.push_back(typed ? want : pred);
    endtask

    // Register write once every outstanding result has drained.
    task automatic write_cfg(input logic idx, input logic [CfgDataWidth-1:0] val);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (line_results_q.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_ACK_TIMEOUT) ack_limit = val;
        else                        gap_len   = val[3:0];
    endtask

    function automatic string out_str(t_out_item o);
        return {$sformatf("scl=%0b sda=%0b drv=%0b need=%0b rv=%0b ",
                          o.scl_level, o.sda_level, o.sda_drive, o.need_byte, o.read_valid),
                $sformatf("rbyte=%02h rlast=%0b busy=%0b done=%0b err=%0b",
                          o.read_byte, o.read_last, o.busy_res, o.done_res, o.error)};
    endfunction

    // Output side stall: a requested hold-off first, otherwise random idling.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 27);
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (line_results_q.size() == 0) begin
                fail_cnt++;
                $display("%0t: result beat with nothing expected: %s", $time,
                         out_str(o_out_data));
            end else begin
                want = line_results_q.pop_front();
                if (o_out_data !== want) begin
                    fail_cnt++;
                    $display("%0t: result mismatch, expected %s", $time, out_str(want));
                    $display("%0t:                  actual   %s", $time, out_str(o_out_data));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, line_results_q.size());
            $display("** i2c_master_register_access: FAILED **");
            $finish;
        end
    end

    initial begin
        t_dir_row   row;
        int         n;
        logic [7:0] ack_sel;
        logic [3:0] gap_sel;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ACK timeout of 1, so that two high samples make an ACK go missing.
        write_cfg(CFG_ACK_TIMEOUT, 8'd1);

        // Idle beats of each request type that does not start a transaction.
        add_row(mk_item(REQ_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 1, PH_IDLE, 1, OUT_IDLE);
        add_row(mk_item(REQ_SUPPLY, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1, PH_IDLE, 1, OUT_IDLE);
        add_row(mk_item(REQ_NONE, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1, PH_IDLE, 1, OUT_IDLE);
        // One-byte write; a second begin and an unrequested byte are dropped.
        add_row(mk_item(REQ_BEGIN, 1'b0, 1'b0, 8'hFF, 8'h00, 8'd1, 8'h00), 1, PH_IDLE, 1, OUT_START);
        add_row(mk_item(REQ_BEGIN, 1'b1, 1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF), 1, PH_IDLE, 1, OUT_START);
        add_row(mk_item(REQ_SUPPLY, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h55), 1, PH_IDLE, 0, '0);
        // Device byte with SDA high all along: the ACK times out and a stop goes out.
        add_row(mk_item(REQ_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 0, PH_ACK_POLL, 0, '0);
        add_row(mk_item(REQ_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 0, PH_STOP_A, 0, '0);
        add_row(mk_item(REQ_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 0, PH_NEED, 0, '0);
        // Ticks and a begin while the data byte is awaited change nothing.
        add_row(mk_item(REQ_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 3, PH_IDLE, 0, '0);
        add_row(mk_item(REQ_BEGIN, 1'b0, 1'b1, 8'h12, 8'h34, 8'h05, 8'h00), 1, PH_IDLE, 0, '0);
        add_row(mk_item(REQ_SUPPLY, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00), 1, PH_IDLE, 0, '0);
        add_row(mk_item(REQ_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 0, PH_IDLE, 0, '0);
        add_row(mk_item(REQ_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 1, PH_IDLE, 1, OUT_IDLE_ERR);
        // Two-byte read from device 0xFF: the read address wraps to 0x00.
        add_row(mk_item(REQ_BEGIN, 1'b0, 1'b1, 8'hFF, 8'hA5, 8'd2, 8'h00), 1, PH_IDLE, 1, OUT_START);
        add_row(mk_item(REQ_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 0, PH_RX_LO, 0, '0);
        add_row(mk_item(REQ_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 0, PH_RXA_LO, 0, '0);
        add_row(mk_item(REQ_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 0, PH_IDLE, 0, '0);
        // Zero byte count, read and write.
        add_row(mk_item(REQ_BEGIN, 1'b0, 1'b1, 8'h40, 8'h5A, 8'd0, 8'h00), 1, PH_IDLE, 1, OUT_START);
        add_row(mk_item(REQ_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 0, PH_IDLE, 0, '0);
        add_row(mk_item(REQ_BEGIN, 1'b1, 1'b0, 8'h7E, 8'h81, 8'd0, 8'h00), 1, PH_IDLE, 1, OUT_START);
        add_row(mk_item(REQ_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00), 0, PH_IDLE, 0, '0);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.reps > 0) begin
                repeat (row.reps) send_item(row.item, row.typed, row.want);
            end else begin
                while (seq_phase != row.stop_at) send_item(row.item, 1'b0, '0);
            end
        end

        // Random traffic in phases, each under its own register settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin ack_sel = 8'd1;   gap_sel = 4'd0;  end
                1: begin ack_sel = 8'd255; gap_sel = 4'd15; end
                2: begin ack_sel = 8'd3;   gap_sel = 4'd1;  end
                3: begin
                    ack_sel = 8'($urandom_range(1, 255));
                    gap_sel = 4'($urandom_range(0, 15));
                end
                4: begin ack_sel = 8'd2;   gap_sel = 4'd15; end
                default: begin ack_sel = ACK_TIMEOUT_RESET; gap_sel = WRITE_GAP_RESET; end
            endcase
            write_cfg(CFG_ACK_TIMEOUT, ack_sel);
            write_cfg(CFG_WRITE_GAP, {4'($urandom_range(0, 15)), gap_sel});
            quiet = (ph == 0);
            // One longer read.
            if (ph == 1) begin
                send_item(mk_item(REQ_BEGIN, 1'($urandom_range(0, 1)), 1'b1,
                                  8'($urandom), 8'($urandom), 8'd10, 8'($urandom)),
                          1'b0, '0);
            end
            n = 0;
            while (n < 60 || seq_phase != PH_IDLE) begin
                send_item(next_item(), 1'b0, '0);
                n++;
                // Long output hold-off while beats keep coming, so the block backs up.
                if (ph == 2 && n == 40) hold_left = 300;
            end
        end
        quiet = 1'b0;

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (line_results_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("** i2c_master_register_access: PASSED **");
        end else begin
            $display("** i2c_master_register_access: FAILED **");
        end
        $finish;
    end

endmodule
